### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`endif

### rtl/core/oms_pkg.sv
// Package with types, constants and helpers of the overshoot motion smoother.
`default_nettype none
package oms_pkg;
    localparam int NumChannels     = 64;
    localparam int MaxSubstepTicks = 16;
    localparam int Modular         = 0;

    localparam logic [1:0] CMD_ADVANCE  = 2'd0;
    localparam logic [1:0] CMD_SET_CUR  = 2'd1;
    localparam logic [1:0] CMD_SET_TGT  = 2'd2;
    localparam logic [1:0] CMD_SET_BOTH = 2'd3;

    localparam logic [2:0] REG_ACCEL_GAIN = 3'd0;
    localparam logic [2:0] REG_WRONG_GAIN = 3'd1;
    localparam logic [2:0] REG_MAX_VEL    = 3'd2;
    localparam logic [2:0] REG_MAX_STEP   = 3'd3;
    localparam logic [2:0] REG_SETTLE_D   = 3'd4;
    localparam logic [2:0] REG_SETTLE_V   = 3'd5;
    localparam logic [2:0] REG_RANGE_LO   = 3'd6;
    localparam logic [2:0] REG_RANGE_HI   = 3'd7;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_LOAD, ST_DIFF, ST_MUL1, ST_MUL2,
        ST_MUL3, ST_ACC, ST_VEL, ST_POS, ST_WRITE, ST_OUT
    } t_state;

    // Configuration set handed to the datapath.
    typedef struct packed {
        logic [30:0]        accel_gain;
        logic [30:0]        wrong_gain;
        logic [30:0]        max_vel;
        logic [30:0]        max_step;
        logic [30:0]        settle_d;
        logic [30:0]        settle_v;
        logic signed [31:0] range_lo;
        logic signed [31:0] range_hi;
    } t_cfg;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) r = 32'sh7fffffff;
        else if (x < -66'sd2147483648) r = 32'sh80000000;
        else r = x[31:0];
        return r;
    endfunction

    // Symmetric clamp by an unsigned 31-bit limit.
    function automatic logic signed [65:0] clamp_sym(input logic signed [65:0] x,
                                                     input logic [30:0] lim);
        logic signed [65:0] l;
        logic signed [65:0] r;
        l = $signed({35'd0, lim});
        if (x > l) r = l;
        else if (x < -l) r = -l;
        else r = x;
        return r;
    endfunction

    // Range wrap when the channel is modular.
    function automatic logic signed [65:0] wrap(input logic signed [65:0] x,
                                                input logic signed [31:0] lo,
                                                input logic signed [31:0] hi,
                                                input logic mod_en);
        logic signed [65:0] len;
        logic signed [65:0] r;
        len = 66'(hi) - 66'(lo);
        r = x;
        if (mod_en) begin
            if (x <= 66'(lo)) r = x + len;
            else if (x > 66'(hi)) r = x - len;
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/core/oms_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`default_nettype none
module oms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire                                          i_clk,
    input  wire                                          i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]                              i_wdata,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

### rtl/core/oms_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
`default_nettype none
module oms_mul (
    input  wire         i_clk,
    input  wire  [31:0] i_a,
    input  wire  [31:0] i_b,
    output logic [63:0] o_p
);
    // One multiplication per cycle, product registered.
    always_ff @(posedge i_clk) begin
        o_p <= 64'(i_a) * 64'(i_b);
    end
endmodule
`default_nettype wire

### rtl/core/overshoot_motion_smoother.sv
// Top level of the overshoot motion smoother.
// Each channel keeps a Q16.16 value, velocity and target in three RAMs. One item is in
// work at a time. A set command passes the read, load, difference, write and output
// states; an advance of T ticks adds ceil(T/MAX_SUBSTEP_TICKS) substeps before the write.
// Each substep multiplies |diff| by the acceleration gain on one shared 32x32 multiplier,
// and when the velocity points away from the target also multiplies both halves of that
// product by the wrong-direction gain; it then updates velocity and then position. An
// item for a channel at or above NUM_CHANNELS answers with zeros without the stores.
// After reset a clearing pass zeroes every channel of the stores, during which no item
// is accepted.
`default_nettype none
module overshoot_motion_smoother #(
    parameter int NUM_CHANNELS      = oms_pkg::NumChannels,
    parameter int MAX_SUBSTEP_TICKS = oms_pkg::MaxSubstepTicks,
    parameter int MODULAR           = oms_pkg::Modular
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [2:0]         i_cfg_index,
    input  wire  [31:0]        i_cfg_data,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire  [1:0]         i_cmd,
    input  wire  [5:0]         i_index,
    input  wire  signed [31:0] i_new_value,
    input  wire  signed [31:0] i_new_velocity,
    input  wire  signed [31:0] i_new_target,
    input  wire  [15:0]        i_ticks,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_value_out,
    output logic signed [31:0] o_velocity_out,
    output logic signed [31:0] o_target_out,
    output logic signed [31:0] o_difference_out
);
    localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [15:0] SubTicks = 16'(MAX_SUBSTEP_TICKS);
    localparam logic ModEn = (MODULAR != 0);

    oms_pkg::t_cfg r_cfg;
    oms_pkg::t_state r_state, n_state;

    logic [1:0]         r_cmd;
    logic [AW-1:0]      r_ch;
    logic               r_bad;
    logic signed [31:0] r_nval, r_nvel, r_ntgt;
    logic [15:0]        r_rem;
    logic [15:0]        r_dt;
    logic signed [31:0] r_val, r_vel, r_tgt, r_diff;
    logic               r_wrong;
    logic [63:0]        r_acc;
    logic [AW:0]        r_clr;
    logic               r_ovalid;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.accel_gain <= 31'd655;
            r_cfg.wrong_gain <= 31'd65536;
            r_cfg.max_vel    <= 31'h7fffffff;
            r_cfg.max_step   <= 31'h7fffffff;
            r_cfg.settle_d   <= '0;
            r_cfg.settle_v   <= '0;
            r_cfg.range_lo   <= 32'sh80000000;
            r_cfg.range_hi   <= 32'sh7fffffff;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                oms_pkg::REG_ACCEL_GAIN: r_cfg.accel_gain <= i_cfg_data[30:0];
                oms_pkg::REG_WRONG_GAIN: r_cfg.wrong_gain <= i_cfg_data[30:0];
                oms_pkg::REG_MAX_VEL:    r_cfg.max_vel    <= i_cfg_data[30:0];
                oms_pkg::REG_MAX_STEP:   r_cfg.max_step   <= i_cfg_data[30:0];
                oms_pkg::REG_SETTLE_D:   r_cfg.settle_d   <= i_cfg_data[30:0];
                oms_pkg::REG_SETTLE_V:   r_cfg.settle_v   <= i_cfg_data[30:0];
                oms_pkg::REG_RANGE_LO:   r_cfg.range_lo   <= i_cfg_data;
                oms_pkg::REG_RANGE_HI:   r_cfg.range_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Difference of the registered state, wrapped and saturated.
    logic signed [31:0] w_diff;
    assign w_diff = oms_pkg::sat32(oms_pkg::wrap(66'(r_tgt) - 66'(r_val),
                                                 r_cfg.range_lo, r_cfg.range_hi, ModEn));

    logic [31:0] w_absd;
    assign w_absd = r_diff[31] ? 32'(-33'(r_diff)) : r_diff;

    // Shared multiplier operand selection: |diff| times gain, then the two halves of
    // the acceleration times the wrong-direction gain.
    logic [31:0] w_ma, w_mb;
    logic [63:0] w_prod;
    always_comb begin
        w_ma = w_absd;
        w_mb = {1'b0, r_cfg.accel_gain};
        if (r_state == oms_pkg::ST_MUL2) begin
            w_ma = w_prod[63:32];
            w_mb = {1'b0, r_cfg.wrong_gain};
        end else if (r_state == oms_pkg::ST_MUL3) begin
            w_ma = {16'd0, r_acc[15:0]};
            w_mb = {1'b0, r_cfg.wrong_gain};
        end
    end

    oms_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    // Velocity update (uses accumulated acceleration).
    logic [32:0]        w_cap;
    logic [48:0]        w_a;
    logic signed [65:0] w_nv;
    logic signed [31:0] w_vel;
    logic [31:0]        w_absv;
    always_comb begin
        w_cap = (r_acc > 64'h1_0000_0000) ? 33'h1_0000_0000 : r_acc[32:0];
        w_a = w_cap * r_dt;
        w_nv = r_diff[31] ? 66'(r_vel) - $signed({17'd0, w_a})
                          : 66'(r_vel) + $signed({17'd0, w_a});
        w_nv = oms_pkg::clamp_sym(w_nv, r_cfg.max_vel);
        w_vel = w_nv[31:0];
        w_absv = w_vel[31] ? 32'(-33'(w_vel)) : w_vel;
        if (w_absd <= {1'b0, r_cfg.settle_d} && w_absv <= {1'b0, r_cfg.settle_v}) begin
            w_vel = '0;
        end
    end

    // Position update from the new velocity; a zero velocity snaps to the target.
    logic signed [48:0] w_step;
    logic signed [65:0] w_x;
    logic signed [31:0] w_val;
    always_comb begin
        w_step = r_vel * $signed({1'b0, r_dt});
        w_x = 66'(r_val) + oms_pkg::clamp_sym(66'(w_step), r_cfg.max_step);
        w_x = oms_pkg::wrap(w_x, r_cfg.range_lo, r_cfg.range_hi, ModEn);
        if (w_x < 66'(r_cfg.range_lo)) w_x = 66'(r_cfg.range_lo);
        if (w_x > 66'(r_cfg.range_hi)) w_x = 66'(r_cfg.range_hi);
        w_val = (r_vel == 0) ? r_tgt : oms_pkg::sat32(w_x);
    end

    // Stores.
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic signed [31:0] w_wv, w_wvel, w_wt;
    logic [31:0]        w_rv, w_rvel, w_rt;
    assign w_we    = (r_state == oms_pkg::ST_CLEAR) || (r_state == oms_pkg::ST_WRITE);
    assign w_waddr = (r_state == oms_pkg::ST_CLEAR) ? r_clr[AW-1:0] : r_ch;
    assign w_wv    = (r_state == oms_pkg::ST_CLEAR) ? '0 : r_val;
    assign w_wvel  = (r_state == oms_pkg::ST_CLEAR) ? '0 : r_vel;
    assign w_wt    = (r_state == oms_pkg::ST_CLEAR) ? '0 : r_tgt;

    oms_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_val (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(w_wv), .i_raddr(r_ch), .o_rdata(w_rv));
    oms_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_vel (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(w_wvel), .i_raddr(r_ch), .o_rdata(w_rvel));
    oms_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_tgt (.i_clk(i_clk), .i_we(w_we),
        .i_waddr(w_waddr), .i_wdata(w_wt), .i_raddr(r_ch), .o_rdata(w_rt));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oms_pkg::ST_CLEAR:  if (r_clr == (AW+1)'(NUM_CHANNELS - 1)) n_state = oms_pkg::ST_IDLE;
            oms_pkg::ST_IDLE:   if (i_valid) n_state = oms_pkg::ST_READ;
            oms_pkg::ST_READ:   n_state = r_bad ? oms_pkg::ST_OUT : oms_pkg::ST_LOAD;
            oms_pkg::ST_LOAD:   n_state = oms_pkg::ST_DIFF;
            oms_pkg::ST_DIFF:   n_state = (r_rem == 0) ? oms_pkg::ST_WRITE : oms_pkg::ST_MUL1;
            oms_pkg::ST_MUL1:   n_state = oms_pkg::ST_MUL2;
            oms_pkg::ST_MUL2:   n_state = r_wrong ? oms_pkg::ST_MUL3 : oms_pkg::ST_VEL;
            oms_pkg::ST_MUL3:   n_state = oms_pkg::ST_ACC;
            oms_pkg::ST_ACC:    n_state = oms_pkg::ST_VEL;
            oms_pkg::ST_VEL:    n_state = oms_pkg::ST_POS;
            oms_pkg::ST_POS:    n_state = oms_pkg::ST_DIFF;
            oms_pkg::ST_WRITE:  n_state = oms_pkg::ST_OUT;
            oms_pkg::ST_OUT:    if (!i_stall) n_state = oms_pkg::ST_IDLE;
            default:            n_state = oms_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_stall = (r_state != oms_pkg::ST_IDLE);
        o_valid = r_ovalid;
    end

    // Sequencer registers and datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= oms_pkg::ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                oms_pkg::ST_CLEAR: r_clr <= r_clr + 1'b1;
                oms_pkg::ST_IDLE: if (i_valid) begin
                    r_cmd  <= i_cmd;
                    r_ch   <= AW'(i_index);
                    r_bad  <= (32'(i_index) >= NUM_CHANNELS);
                    r_nval <= i_new_value;
                    r_nvel <= i_new_velocity;
                    r_ntgt <= i_new_target;
                    r_rem  <= (i_cmd == oms_pkg::CMD_ADVANCE) ? i_ticks : 16'd0;
                end
                // A channel outside the store answers with zeros at once.
                oms_pkg::ST_READ: if (r_bad) begin
                    r_ovalid <= 1'b1;
                    o_value_out      <= '0;
                    o_velocity_out   <= '0;
                    o_target_out     <= '0;
                    o_difference_out <= '0;
                end
                oms_pkg::ST_LOAD: begin
                    r_val <= w_rv;
                    r_vel <= w_rvel;
                    r_tgt <= w_rt;
                    if (r_cmd == oms_pkg::CMD_SET_CUR || r_cmd == oms_pkg::CMD_SET_BOTH) begin
                        r_val <= r_nval;
                        r_vel <= r_nvel;
                    end
                    if (r_cmd == oms_pkg::CMD_SET_TGT || r_cmd == oms_pkg::CMD_SET_BOTH) begin
                        r_tgt <= r_ntgt;
                    end
                end
                oms_pkg::ST_DIFF: begin
                    r_diff  <= w_diff;
                    r_dt    <= (r_rem < SubTicks) ? r_rem : SubTicks;
                    r_wrong <= (r_vel[31] && !w_diff[31] && w_diff != 0) ||
                               (!r_vel[31] && r_vel != 0 && w_diff[31]);
                end
                oms_pkg::ST_MUL1: ;
                oms_pkg::ST_MUL2: r_acc <= w_prod >> 16;
                oms_pkg::ST_MUL3: r_acc <= w_prod;
                oms_pkg::ST_ACC:  r_acc <= r_acc + (w_prod >> 16);
                oms_pkg::ST_VEL:  r_vel <= w_vel;
                oms_pkg::ST_POS: begin
                    r_val <= w_val;
                    r_rem <= r_rem - r_dt;
                end
                oms_pkg::ST_WRITE: begin
                    r_ovalid <= 1'b1;
                    o_value_out      <= r_val;
                    o_velocity_out   <= r_vel;
                    o_target_out     <= r_tgt;
                    o_difference_out <= w_diff;
                end
                oms_pkg::ST_OUT: if (!i_stall) begin
                    r_ovalid <= 1'b0;
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

### rtl/core/oms_checker.sv
// Port-level checker for the overshoot motion smoother, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module oms_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire        o_valid,
    input wire        i_stall,
    input wire [31:0] o_value_out
);
    `CHK_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_value_out))
    `CHK_IMPL(a_busy_out, i_clk, i_rst_n, o_valid, o_stall)
    `CHK_NEXT(a_take_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
endmodule

bind overshoot_motion_smoother oms_checker u_oms_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_value_out(o_value_out)
);
`default_nettype wire
